/* rtl/tcq_pkg.sv */
// Shared types, codes and constants of the two-class queue with aging.
`timescale 1ns / 1ps
package tcq_pkg;

    // Field widths
    localparam int ID_W     = 16;
    localparam int STAMP_W  = 32;
    localparam int THR_W    = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int PROMO_W  = 5;

    // Reset value of the age threshold, in ticks
    localparam logic [THR_W-1:0] AGE_THRESHOLD_RESET = 16'd400;

    // Action codes of an input beat
    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

    // Status codes of a result beat
    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK    = 3'd4;

    // One queue entry: the item id and its enqueue time
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the input beat
        logic exec;      // run a push, a tick or an unused action
        logic promote;   // move the regular head to the priority tail
        logic serve;     // pop one item, if any, and form the result
        logic load_out;  // move the result into the output register
    } tcq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_pop;       // the beat on the input port is a pop
        logic can_promote;  // the regular head is aged and there is room
        logic out_free;     // the output register can take a result
    } tcq_sts_t;

endpackage

/* rtl/two_class_queue_with_aging.sv */
// Top level of the two-class queue with aging: controller plus datapath.
// Push, tick: the beat is captured and executed, then its result is loaded into the output
// register once that is free. Pop: both heads are read, aged regular heads are promoted one
// at a time, each waiting on a queue RAM read, then one item is served. Beats do not overlap.
// A new input beat is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) empties both queues, clears time, sets threshold to 400.
`timescale 1ns / 1ps
module two_class_queue_with_aging #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] item_id
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] is_priority
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] popped_id, [20:16] promoted_count, rest zero
    output logic [3:0]  m_tuser,   // [2:0] status, [3] popped_from_priority
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    import tcq_pkg::*;

    tcq_cmd_t cmd;
    tcq_sts_t sts;

    // Sequencer
    tcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Queues, time and result path
    tcq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* rtl/tcq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tcq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcq_ctrl.sv */
// Controller state machine that sequences push, tick and pop with aging.
`timescale 1ns / 1ps
module tcq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tcq_pkg::tcq_sts_t sts,
    output tcq_pkg::tcq_cmd_t cmd
);

    import tcq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.in_pop ? S_RD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_RD:
            begin
                // Head entries are read out during this cycle
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.can_promote)
                begin
                    cmd.promote = 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    cmd.serve  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/tcq_dpath.sv */
// Datapath: both queues, the time counter, the threshold and the output register.
`timescale 1ns / 1ps
module tcq_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [3:0]        m_tuser,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  tcq_pkg::tcq_cmd_t cmd,
    output tcq_pkg::tcq_sts_t sts
);

    import tcq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

    // Control state
    logic [STAMP_W-1:0] time_reg, time_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [AW-1:0]      p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [CW-1:0]      p_cnt_reg, p_cnt_next;
    logic [AW-1:0]      r_head_reg, r_head_next, r_tail_reg, r_tail_next;
    logic [CW-1:0]      r_cnt_reg, r_cnt_next;
    logic [PROMO_W-1:0] promo_reg, promo_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers
    logic [ACTION_W-1:0] in_action_reg, in_action_next;
    logic [ID_W-1:0]     in_id_reg, in_id_next;
    logic                in_prio_reg, in_prio_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic                res_from_reg, res_from_next;
    logic [PROMO_W-1:0]  res_promo_reg, res_promo_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic                out_from_reg, out_from_next;
    logic [PROMO_W-1:0]  out_promo_reg, out_promo_next;

    // RAM ports
    logic   p_we, r_we;
    entry_t p_wdata, r_wdata, p_rdata, r_rdata;

    logic               p_full, r_full, p_empty, r_empty;
    logic [STAMP_W-1:0] reg_age;

    assign p_full  = (p_cnt_reg == FULL_CNT);
    assign r_full  = (r_cnt_reg == FULL_CNT);
    assign p_empty = (p_cnt_reg == '0);
    assign r_empty = (r_cnt_reg == '0);

    // Age of the regular head, with wrapping time
    assign reg_age = time_reg - r_rdata.stamp;

    assign sts.in_pop      = (s_tuser[1:0] == ACT_POP);
    assign sts.can_promote = !r_empty && !p_full && (reg_age >= {16'd0, thr_reg});
    assign sts.out_free    = !out_valid_reg || m_tready;

    // Queue write ports
    always_comb
    begin
        p_we    = 1'b0;
        r_we    = 1'b0;
        p_wdata = r_rdata;
        r_wdata = '{stamp: time_reg, id: in_id_reg};
        if (cmd.exec && in_action_reg == ACT_PUSH)
        begin
            if (in_prio_reg)
            begin
                p_we    = !p_full;
                p_wdata = '{stamp: time_reg, id: in_id_reg};
            end
            else
            begin
                r_we = !r_full;
            end
        end
        if (cmd.promote)
        begin
            p_we = 1'b1;
        end
    end

    // Next values of all registers
    always_comb
    begin
        time_next       = time_reg;
        thr_next        = thr_reg;
        p_head_next     = p_head_reg;
        p_tail_next     = p_tail_reg;
        p_cnt_next      = p_cnt_reg;
        r_head_next     = r_head_reg;
        r_tail_next     = r_tail_reg;
        r_cnt_next      = r_cnt_reg;
        promo_next      = promo_reg;
        out_valid_next  = out_valid_reg;
        in_action_next  = in_action_reg;
        in_id_next      = in_id_reg;
        in_prio_next    = in_prio_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_from_next   = res_from_reg;
        res_promo_next  = res_promo_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_from_next   = out_from_reg;
        out_promo_next  = out_promo_reg;

        if (cfg_we)
        begin
            thr_next = cfg_wdata;
        end

        // Capture the input beat
        if (cmd.load_in)
        begin
            in_action_next = s_tuser[1:0];
            in_prio_next   = s_tuser[2];
            in_id_next     = s_tdata;
            promo_next     = '0;
        end

        // Push, tick or unused action
        if (cmd.exec)
        begin
            res_id_next     = '0;
            res_from_next   = 1'b0;
            res_promo_next  = '0;
            res_status_next = ST_TICK;
            case (in_action_reg)
                ACT_PUSH:
                begin
                    if (in_prio_reg)
                    begin
                        if (p_full)
                        begin
                            res_status_next = ST_DROPPED;
                        end
                        else
                        begin
                            res_status_next = ST_PUSHED;
                            p_tail_next = (p_tail_reg == LAST_PTR) ? '0 : p_tail_reg + 1'b1;
                            p_cnt_next  = p_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (r_full)
                        begin
                            res_status_next = ST_DROPPED;
                        end
                        else
                        begin
                            res_status_next = ST_PUSHED;
                            r_tail_next = (r_tail_reg == LAST_PTR) ? '0 : r_tail_reg + 1'b1;
                            r_cnt_next  = r_cnt_reg + 1'b1;
                        end
                    end
                end
                ACT_TICK:
                begin
                    time_next = time_reg + 1'b1;
                end
                default:
                begin
                    res_status_next = ST_TICK;
                end
            endcase
        end

        // Move one aged regular head to the priority tail
        if (cmd.promote)
        begin
            p_tail_next = (p_tail_reg == LAST_PTR) ? '0 : p_tail_reg + 1'b1;
            p_cnt_next  = p_cnt_reg + 1'b1;
            r_head_next = (r_head_reg == LAST_PTR) ? '0 : r_head_reg + 1'b1;
            r_cnt_next  = r_cnt_reg - 1'b1;
            if (promo_reg != '1)
            begin
                promo_next = promo_reg + 1'b1;
            end
        end

        // Serve the pop, priority queue first
        if (cmd.serve)
        begin
            res_promo_next = promo_reg;
            if (!p_empty)
            begin
                res_status_next = ST_POPPED;
                res_id_next     = p_rdata.id;
                res_from_next   = 1'b1;
                p_head_next = (p_head_reg == LAST_PTR) ? '0 : p_head_reg + 1'b1;
                p_cnt_next  = p_cnt_reg - 1'b1;
            end
            else if (!r_empty)
            begin
                res_status_next = ST_POPPED;
                res_id_next     = r_rdata.id;
                res_from_next   = 1'b0;
                r_head_next = (r_head_reg == LAST_PTR) ? '0 : r_head_reg + 1'b1;
                r_cnt_next  = r_cnt_reg - 1'b1;
            end
            else
            begin
                res_status_next = ST_EMPTY;
                res_id_next     = '0;
                res_from_next   = 1'b0;
            end
        end

        // Output register
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_from_next   = res_from_reg;
            out_promo_next  = res_promo_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            thr_reg       <= AGE_THRESHOLD_RESET;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            p_cnt_reg     <= '0;
            r_head_reg    <= '0;
            r_tail_reg    <= '0;
            r_cnt_reg     <= '0;
            promo_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            time_reg      <= time_next;
            thr_reg       <= thr_next;
            p_head_reg    <= p_head_next;
            p_tail_reg    <= p_tail_next;
            p_cnt_reg     <= p_cnt_next;
            r_head_reg    <= r_head_next;
            r_tail_reg    <= r_tail_next;
            r_cnt_reg     <= r_cnt_next;
            promo_reg     <= promo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_action_reg  <= in_action_next;
        in_id_reg      <= in_id_next;
        in_prio_reg    <= in_prio_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_from_reg   <= res_from_next;
        res_promo_reg  <= res_promo_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_from_reg   <= out_from_next;
        out_promo_reg  <= out_promo_next;
    end

    // Queue storage; each read port follows its head pointer
    tcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_prio_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_tail_reg),
        .wdata (p_wdata),
        .raddr (p_head_reg),
        .rdata (p_rdata)
    );

    tcq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_reg_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_tail_reg),
        .wdata (r_wdata),
        .raddr (r_head_reg),
        .rdata (r_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_promo_reg, out_id_reg};
    assign m_tuser  = {out_from_reg, out_status_reg};

endmodule
